FILE: rtl/iso_datetime_text_parser_top_assert.svh
// Assertion macros for the ISO date/time text parser.
// Used by iso_datetime_text_parser_top; expects clk and arst_n in scope.
`ifndef ISO_DATETIME_TEXT_PARSER_TOP_ASSERT_SVH
`define ISO_DATETIME_TEXT_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define IDTP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IDTP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/idtp_pkg.sv
// Shared types, codes and tables for the ISO date/time text parser.
// No dependencies; imported by every RTL module of the block.
package idtp_pkg;

	localparam int FRACTION_DIGITS = 6;
	localparam int FRAC_KEEP = (FRACTION_DIGITS < 6) ? FRACTION_DIGITS : 6;

	localparam int YEAR_W  = 14;
	localparam int FLD_W   = 7;
	localparam int US_W    = 20;
	localparam int ZOFF_W  = 14;
	localparam int CNT_W   = 3;
	localparam int ODATA_W = 88;

	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
	localparam logic [US_W-1:0]   US_MAX   = 20'd999999;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_Z     = 8'h5a;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;

	typedef enum logic [3:0] {
		PH_START, PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE,
		PH_SECOND, PH_FRAC, PH_WS, PH_TZH, PH_TZM, PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		MODE_DATE, MODE_TIME, MODE_DATETIME, MODE_RSVD
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK, ST_SYNTAX, ST_BAD_DATE, ST_BAD_TIME
	} status_t;

	typedef struct packed {
		phase_t            phase;
		mode_t             mode;
		logic              fail;
		logic [CNT_W-1:0]  cnt;
		logic [YEAR_W-1:0] year;
		logic [15:0]       ydig;   // year as four BCD digits, for the leap rule
		logic [FLD_W-1:0]  month;
		logic [FLD_W-1:0]  day;
		logic [FLD_W-1:0]  hour;
		logic [FLD_W-1:0]  minute;
		logic [FLD_W-1:0]  second;
		logic [US_W-1:0]   frac;
		logic              zpres;
		logic              zneg;
		logic [FLD_W-1:0]  zh;
		logic [FLD_W-1:0]  zm;
	} parse_st_t;

	typedef struct packed {
		status_t                  status;
		logic [YEAR_W-1:0]        year;
		logic [FLD_W-1:0]         month;
		logic [FLD_W-1:0]         day;
		logic [FLD_W-1:0]         hour;
		logic [FLD_W-1:0]         minute;
		logic [FLD_W-1:0]         second;
		logic [US_W-1:0]          microsecond;
		logic                     zone_present;
		logic signed [ZOFF_W-1:0] zone_offset;
	} result_t;

	function automatic logic [4:0] month_days(logic [3:0] m);
		logic [4:0] r;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			4'd2: r = 5'd28;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [16:0] frac_weight(logic [CNT_W-1:0] i);
		logic [16:0] r;
		case (i)
			3'd0: r = 17'd100000;
			3'd1: r = 17'd10000;
			3'd2: r = 17'd1000;
			3'd3: r = 17'd100;
			3'd4: r = 17'd10;
			3'd5: r = 17'd1;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/iso_datetime_text_parser_top.sv
// ISO 8601 date / time / datetime text parser, top level.
// Input register, idtp_parse (grammar state), idtp_result (checks), output register.
// Depends on idtp_pkg and iso_datetime_text_parser_top_assert.svh.
//
// Usage:
//   Slave side: one character per beat. s_tdata carries the byte, s_tuser the
//   mode (0 date, 1 time, 2 datetime), taken from the first beat of a string;
//   s_tlast marks the final character of the string.
//   Master side: one beat per string, issued for the s_tlast beat only.
//   m_tuser is the status (0 ok, 1 syntax, 2 bad date, 3 bad time); m_tdata
//   holds the parsed fields, all zero on a syntax error.
// Throughput: one character per clock across strings, held only by an output stall.
// Result path: after its last character is accepted, the result passes the parse
//   state snapshot, then the output register, before it is presented.
// Reset: clears all valids and the parse state; the next beat starts a string.
// Stall: while m_tready is low the result holds; one further finished string
//   can wait in stage 2, and characters keep flowing until the final character
//   of the string after that is registered, at which point s_tready drops.
module iso_datetime_text_parser_top import idtp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] char_code
	input  logic               s_tlast,
	input  logic [1:0]         s_tuser,   // [1:0] mode
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [ODATA_W-1:0] m_tdata,   // year, month, day, hour, minute, second,
	                                      // microsecond, zone_present,
	                                      // zone_offset_minutes, zero pad
	output logic [1:0]         m_tuser    // [1:0] status
);

`include "iso_datetime_text_parser_top_assert.svh"

	logic       in_valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic [1:0] mode_s1;
	logic       adv_s1;
	logic       snap_valid;
	logic       snap_free;
	logic       out_load;
	parse_st_t  snap;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;

	assign out_load  = snap_valid && (!out_valid_q || m_tready);
	assign snap_free = !snap_valid || out_load;
	assign adv_s1    = in_valid_s1 && (!last_s1 || snap_free);
	assign s_tready  = !in_valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				in_valid_s1 <= 1'b1;
			else if (adv_s1)
				in_valid_s1 <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
			mode_s1 <= s_tuser;
		end
		if (out_load)
			out_q <= res;
	end

	idtp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv_s1),
		.char_code  (char_s1),
		.last_char  (last_s1),
		.mode       (mode_s1),
		.pop        (out_load),
		.snap_valid (snap_valid),
		.snap       (snap)
	);

	idtp_result u_result (
		.s (snap),
		.r (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {4'b0, out_q.zone_offset, out_q.zone_present, out_q.microsecond,
		out_q.second, out_q.minute, out_q.hour, out_q.day, out_q.month, out_q.year};

	`IDTP_ASSERT_IMP(a_syntax_zero, m_tvalid && m_tuser == ST_SYNTAX, m_tdata == '0, "syntax error beat carries field data")
	`IDTP_ASSERT_IMP(a_us_range, m_tvalid, m_tdata[68:49] <= US_MAX, "microsecond above 999999")
	`IDTP_ASSERT_IMP(a_no_zone_off, m_tvalid && !m_tdata[69], m_tdata[83:70] == '0, "offset without zone")
	`IDTP_ASSERT_NXT(a_load_shows, out_load, m_tvalid, "loaded result not presented")

endmodule

FILE: rtl/idtp_parse.sv
// Grammar tracker: phase register and field accumulators, one character per beat.
// Snapshots the finished string into a stage-2 register. Depends on idtp_pkg.
module idtp_parse import idtp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  logic [7:0] char_code,
	input  logic      last_char,
	input  logic [1:0] mode,
	input  logic      pop,
	output logic      snap_valid,
	output parse_st_t snap
);

	parse_st_t st_q;
	parse_st_t cur;
	parse_st_t nxt;
	parse_st_t snap_s2;
	logic      snap_valid_s2;
	logic      dig;
	logic [3:0] d;
	logic      dt;
	logic [20:0] fprod;

	function automatic logic [FLD_W-1:0] mac7(logic [FLD_W-1:0] a, logic [3:0] v);
		logic [10:0] t;
		t = 11'(a) * 11'd10 + 11'(v);
		return t[FLD_W-1:0];
	endfunction

	function automatic parse_st_t zone_start(parse_st_t s, logic [7:0] c);
		parse_st_t r;
		r = s;
		if (c == CH_SPACE || c == CH_TAB) begin
			r.phase = PH_WS;
		end else if (c == CH_Z) begin
			r.zpres = 1'b1;
			r.zneg  = 1'b0;
			r.zh    = '0;
			r.zm    = '0;
			r.phase = PH_DONE;
		end else if (c == CH_PLUS || c == CH_MINUS) begin
			r.zpres = 1'b1;
			r.zneg  = (c == CH_MINUS);
			r.zh    = '0;
			r.zm    = '0;
			r.cnt   = '0;
			r.phase = PH_TZH;
		end else begin
			r.fail = 1'b1;
		end
		return r;
	endfunction

	always_comb begin
		cur = st_q;
		if (st_q.phase == PH_START) begin
			cur.mode  = mode_t'(mode);
			cur.fail  = (mode_t'(mode) == MODE_RSVD);
			cur.phase = (mode_t'(mode) == MODE_TIME) ? PH_HOUR : PH_YEAR;
			cur.cnt   = '0;
		end
		dig   = (char_code >= CH_0) && (char_code <= CH_9);
		d     = dig ? char_code[3:0] : 4'd0;
		dt    = (cur.mode == MODE_DATETIME);
		fprod = 21'(d) * 21'(frac_weight(cur.cnt));
		nxt   = cur;
		if (!cur.fail) begin
			case (cur.phase)
				PH_YEAR: begin
					if (dig && cur.cnt < 3'd4) begin
						nxt.year = YEAR_W'(18'(cur.year) * 18'd10 + 18'(d));
						nxt.ydig = {cur.ydig[11:0], d};
						nxt.cnt  = cur.cnt + 3'd1;
					end else if (char_code == CH_DASH && cur.cnt == 3'd4) begin
						nxt.phase = PH_MONTH;
						nxt.cnt   = '0;
					end else begin
						nxt.fail = 1'b1;
					end
				end
				PH_MONTH: begin
					if (dig && cur.cnt < 3'd2) begin
						nxt.month = mac7(cur.month, d);
						nxt.cnt   = cur.cnt + 3'd1;
					end else if (char_code == CH_DASH && cur.cnt != 3'd0) begin
						nxt.phase = PH_DAY;
						nxt.cnt   = '0;
					end else begin
						nxt.fail = 1'b1;
					end
				end
				PH_DAY: begin
					if (dig && cur.cnt < 3'd2) begin
						nxt.day = mac7(cur.day, d);
						nxt.cnt = cur.cnt + 3'd1;
					end else if (dt && cur.cnt != 3'd0 &&
						(char_code == CH_T || char_code == CH_SPACE)) begin
						nxt.phase = PH_HOUR;
						nxt.cnt   = '0;
					end else begin
						nxt.fail = 1'b1;
					end
				end
				PH_HOUR: begin
					if (dig && cur.cnt < 3'd2) begin
						nxt.hour = mac7(cur.hour, d);
						nxt.cnt  = cur.cnt + 3'd1;
					end else if (char_code == CH_COLON && cur.cnt != 3'd0) begin
						nxt.phase = PH_MINUTE;
						nxt.cnt   = '0;
					end else begin
						nxt.fail = 1'b1;
					end
				end
				PH_MINUTE: begin
					if (dig && cur.cnt < 3'd2) begin
						nxt.minute = mac7(cur.minute, d);
						nxt.cnt    = cur.cnt + 3'd1;
					end else if (char_code == CH_COLON && cur.cnt != 3'd0) begin
						nxt.phase = PH_SECOND;
						nxt.cnt   = '0;
					end else if (dt && cur.cnt != 3'd0) begin
						nxt = zone_start(cur, char_code);
					end else begin
						nxt.fail = 1'b1;
					end
				end
				PH_SECOND: begin
					if (dig && cur.cnt < 3'd2) begin
						nxt.second = mac7(cur.second, d);
						nxt.cnt    = cur.cnt + 3'd1;
					end else if ((char_code == CH_DOT || char_code == CH_COMMA) &&
						cur.cnt != 3'd0) begin
						nxt.phase = PH_FRAC;
						nxt.cnt   = '0;
					end else if (dt && cur.cnt != 3'd0) begin
						nxt = zone_start(cur, char_code);
					end else begin
						nxt.fail = 1'b1;
					end
				end
				PH_FRAC: begin
					if (dig) begin
						if (cur.cnt < CNT_W'(FRAC_KEEP))
							nxt.frac = cur.frac + fprod[US_W-1:0];
						// count saturates; only "any digit" and "below kept" matter
						if (cur.cnt != 3'd7)
							nxt.cnt = cur.cnt + 3'd1;
					end else if (dt && cur.cnt != 3'd0) begin
						nxt = zone_start(cur, char_code);
					end else begin
						nxt.fail = 1'b1;
					end
				end
				PH_WS: begin
					nxt = zone_start(cur, char_code);
				end
				PH_TZH: begin
					if (dig && cur.cnt < 3'd2) begin
						nxt.zh  = mac7(cur.zh, d);
						nxt.cnt = cur.cnt + 3'd1;
					end else if (cur.cnt == 3'd2 && char_code == CH_COLON) begin
						nxt.phase = PH_TZM;
						nxt.cnt   = '0;
					end else if (cur.cnt == 3'd2 && dig) begin
						nxt.zm    = FLD_W'(d);
						nxt.phase = PH_TZM;
						nxt.cnt   = 3'd1;
					end else begin
						nxt.fail = 1'b1;
					end
				end
				PH_TZM: begin
					if (dig && cur.cnt < 3'd2) begin
						nxt.zm  = mac7(cur.zm, d);
						nxt.cnt = cur.cnt + 3'd1;
					end else begin
						nxt.fail = 1'b1;
					end
				end
				default: begin
					nxt.fail = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= '0;
			snap_valid_s2 <= 1'b0;
		end else begin
			if (step) begin
				st_q <= last_char ? parse_st_t'('0) : nxt;
			end
			if (step && last_char) begin
				snap_valid_s2 <= 1'b1;
			end else if (pop) begin
				snap_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_char) begin
			snap_s2 <= nxt;
		end
	end

	assign snap_valid = snap_valid_s2;
	assign snap       = snap_s2;

endmodule

FILE: rtl/idtp_result.sv
// Checks grammar completion, calendar and clock ranges; builds the zone offset.
// Purely combinational; depends on idtp_pkg.
module idtp_result import idtp_pkg::*; (
	input  parse_st_t s,
	output result_t   r
);

	logic        end_ok;
	logic        date_ok;
	logic        time_ok;
	logic        y4;
	logic        c4;
	logic        y100;
	logic        leap;
	logic [4:0]  lim;
	logic [ZOFF_W-1:0] mag;
	status_t     st;

	always_comb begin
		case (s.phase)
			PH_DAY:    end_ok = (s.mode == MODE_DATE) && (s.cnt != 3'd0);
			PH_MINUTE,
			PH_SECOND,
			PH_FRAC:   end_ok = (s.mode != MODE_DATE) && (s.cnt != 3'd0);
			PH_WS,
			PH_DONE:   end_ok = 1'b1;
			PH_TZH,
			PH_TZM:    end_ok = (s.cnt == 3'd2);
			default:   end_ok = 1'b0;
		endcase
	end

	// divisibility from the BCD digits: 10a+b is a multiple of 4 iff 2a+b is
	assign y4   = (2'({s.ydig[4], 1'b0}) + s.ydig[1:0]) == 2'd0;
	assign c4   = (2'({s.ydig[12], 1'b0}) + s.ydig[9:8]) == 2'd0;
	assign y100 = (s.ydig[7:0] == 8'd0);
	assign leap = y4 && (!y100 || c4);
	assign lim  = (s.month == 7'd2) ? (leap ? 5'd29 : 5'd28) : month_days(s.month[3:0]);

	assign date_ok = (s.month >= 7'd1) && (s.month <= 7'd12) &&
		(s.day >= 7'd1) && (s.day <= 7'd31) &&
		(s.year >= 14'd1) && (s.year <= YEAR_MAX) &&
		(s.day <= 7'(lim));

	assign time_ok = (s.hour <= 7'd23) && (s.minute <= 7'd59) &&
		(s.second <= 7'd59) && (s.frac <= US_MAX);

	always_comb begin
		if (s.fail || !end_ok)
			st = ST_SYNTAX;
		else if (s.mode != MODE_TIME && !date_ok)
			st = ST_BAD_DATE;
		else if (s.mode != MODE_DATE && !time_ok)
			st = ST_BAD_TIME;
		else
			st = ST_OK;
	end

	assign mag = ZOFF_W'(s.zh) * ZOFF_W'(60) + ZOFF_W'(s.zm);

	always_comb begin
		r = '0;
		r.status = st;
		if (st != ST_SYNTAX) begin
			r.year         = s.year;
			r.month        = s.month;
			r.day          = s.day;
			r.hour         = s.hour;
			r.minute       = s.minute;
			r.second       = s.second;
			r.microsecond  = s.frac;
			r.zone_present = s.zpres;
			r.zone_offset  = s.zneg ? $signed(-mag) : $signed(mag);
		end
	end

endmodule

FILE: verif/tb_iso_datetime_text_parser_top.sv
`timescale 1ns / 100ps
// Testbench for iso_datetime_text_parser_top: streams date, time and datetime text one
// character per beat and checks every result beat against a parser model kept here.
// Depends on idtp_pkg and the block's RTL only.
module tb_iso_datetime_text_parser_top;
	import idtp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_CHARS   = 1200;
	localparam int MAX_IDLE       = 13;
	localparam int HOLD_CYCLES    = 500;
	localparam int FIELD_BITS     = $bits(result_t) - 2;
	localparam string ALPHABET    = "0123456789-:T .,Z+\t";

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata  = '0;
	logic               s_tlast  = 1'b0;
	logic [1:0]         s_tuser  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [ODATA_W-1:0] m_tdata;
	logic [1:0]         m_tuser;

	// parser model state
	phase_t      pp_phase;
	mode_t       pp_mode;
	bit          pp_bad;
	int unsigned pp_cnt, pp_year, pp_month, pp_day;
	int unsigned pp_hour, pp_minute, pp_second, pp_frac;
	bit          pp_zpres, pp_zneg;
	int unsigned pp_zh, pp_zm;

	result_t    due_results[$];
	logic [7:0] text_buf[$];

	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int rx_hold = 0;
	int errors = 0;
	int chars_sent = 0;
	int strings_sent = 0;
	int quiet_cycles = 0;
	int status_count[4] = '{0, 0, 0, 0};

	iso_datetime_text_parser_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void parse_clear();
		pp_phase = PH_START;
		pp_mode = MODE_DATE;
		pp_bad = 1'b0;
		pp_cnt = 0;
		pp_year = 0;
		pp_month = 0;
		pp_day = 0;
		pp_hour = 0;
		pp_minute = 0;
		pp_second = 0;
		pp_frac = 0;
		pp_zpres = 1'b0;
		pp_zneg = 1'b0;
		pp_zh = 0;
		pp_zm = 0;
	endfunction

	function automatic int unsigned add_digit(int unsigned acc, int unsigned d);
		return (acc * 10 + d) % 128;
	endfunction

	// character after the time part in datetime mode: blank, Z or sign
	function automatic void zone_begin(logic [7:0] c);
		if (c == CH_SPACE || c == CH_TAB) begin
			pp_phase = PH_WS;
		end else if (c == CH_Z) begin
			pp_zpres = 1'b1;
			pp_phase = PH_DONE;
		end else if (c == CH_PLUS || c == CH_MINUS) begin
			pp_zpres = 1'b1;
			pp_zneg = (c == CH_MINUS);
			pp_cnt = 0;
			pp_phase = PH_TZH;
		end else begin
			pp_bad = 1'b1;
		end
	endfunction

	function automatic void parse_char(logic [7:0] c);
		bit          dig;
		bit          dt;
		int unsigned d;
		int unsigned w;
		dig = (c >= CH_0 && c <= CH_9);
		d = dig ? c - CH_0 : 0;
		dt = (pp_mode == MODE_DATETIME);
		case (pp_phase)
			PH_YEAR: begin
				if (dig && pp_cnt < 4) begin
					pp_year = (pp_year * 10 + d) % 16384;
					pp_cnt++;
				end else if (c == CH_DASH && pp_cnt == 4) begin
					pp_phase = PH_MONTH;
					pp_cnt = 0;
				end else pp_bad = 1'b1;
			end
			PH_MONTH: begin
				if (dig && pp_cnt < 2) begin
					pp_month = add_digit(pp_month, d);
					pp_cnt++;
				end else if (c == CH_DASH && pp_cnt >= 1) begin
					pp_phase = PH_DAY;
					pp_cnt = 0;
				end else pp_bad = 1'b1;
			end
			PH_DAY: begin
				if (dig && pp_cnt < 2) begin
					pp_day = add_digit(pp_day, d);
					pp_cnt++;
				end else if (dt && pp_cnt >= 1 && (c == CH_T || c == CH_SPACE)) begin
					pp_phase = PH_HOUR;
					pp_cnt = 0;
				end else pp_bad = 1'b1;
			end
			PH_HOUR: begin
				if (dig && pp_cnt < 2) begin
					pp_hour = add_digit(pp_hour, d);
					pp_cnt++;
				end else if (c == CH_COLON && pp_cnt >= 1) begin
					pp_phase = PH_MINUTE;
					pp_cnt = 0;
				end else pp_bad = 1'b1;
			end
			PH_MINUTE: begin
				if (dig && pp_cnt < 2) begin
					pp_minute = add_digit(pp_minute, d);
					pp_cnt++;
				end else if (c == CH_COLON && pp_cnt >= 1) begin
					pp_phase = PH_SECOND;
					pp_cnt = 0;
				end else if (dt && pp_cnt >= 1) zone_begin(c);
				else pp_bad = 1'b1;
			end
			PH_SECOND: begin
				if (dig && pp_cnt < 2) begin
					pp_second = add_digit(pp_second, d);
					pp_cnt++;
				end else if ((c == CH_DOT || c == CH_COMMA) && pp_cnt >= 1) begin
					pp_phase = PH_FRAC;
					pp_cnt = 0;
				end else if (dt && pp_cnt >= 1) zone_begin(c);
				else pp_bad = 1'b1;
			end
			PH_FRAC: begin
				if (dig) begin
					// digits past the sixth are dropped
					if (pp_cnt < FRACTION_DIGITS && pp_cnt < 6) begin
						w = 100000;
						repeat (pp_cnt) w = w / 10;
						pp_frac += d * w;
					end
					if (pp_cnt < 15) pp_cnt++;
				end else if (dt && pp_cnt >= 1) zone_begin(c);
				else pp_bad = 1'b1;
			end
			PH_WS: zone_begin(c);
			PH_TZH: begin
				if (dig && pp_cnt < 2) begin
					pp_zh = add_digit(pp_zh, d);
					pp_cnt++;
				end else if (pp_cnt == 2 && c == CH_COLON) begin
					pp_phase = PH_TZM;
					pp_cnt = 0;
				end else if (pp_cnt == 2 && dig) begin
					pp_zm = d;
					pp_phase = PH_TZM;
					pp_cnt = 1;
				end else pp_bad = 1'b1;
			end
			PH_TZM: begin
				if (dig && pp_cnt < 2) begin
					pp_zm = add_digit(pp_zm, d);
					pp_cnt++;
				end else pp_bad = 1'b1;
			end
			default: pp_bad = 1'b1;
		endcase
	endfunction

	function automatic bit parse_complete();
		case (pp_phase)
			PH_DAY:                        return pp_mode == MODE_DATE && pp_cnt >= 1;
			PH_MINUTE, PH_SECOND, PH_FRAC: return pp_mode != MODE_DATE && pp_cnt >= 1;
			PH_WS, PH_DONE:                return 1'b1;
			PH_TZH, PH_TZM:                return pp_cnt == 2;
			default:                       return 1'b0;
		endcase
	endfunction

	function automatic bit calendar_valid();
		int unsigned limit;
		bit          leap;
		if (pp_month < 1 || pp_month > 12 || pp_day < 1 || pp_year < 1 || pp_year > 9999)
			return 1'b0;
		leap = (pp_year % 4 == 0) && ((pp_year % 100 != 0) || (pp_year % 400 == 0));
		case (pp_month)
			4, 6, 9, 11: limit = 30;
			2:           limit = leap ? 29 : 28;
			default:     limit = 31;
		endcase
		return pp_day <= limit;
	endfunction

	function automatic bit clock_valid();
		return pp_hour <= 23 && pp_minute <= 59 && pp_second <= 59 && pp_frac <= 999999;
	endfunction

	// advance the model by one accepted beat; a final character queues its result
	function automatic void track_char(logic [7:0] c, logic last, logic [1:0] mode);
		result_t r;
		int      off;
		if (pp_phase == PH_START) begin
			pp_mode = mode_t'(mode);
			pp_bad = (pp_mode == MODE_RSVD);
			pp_phase = (pp_mode == MODE_TIME) ? PH_HOUR : PH_YEAR;
			pp_cnt = 0;
		end
		if (!pp_bad) parse_char(c);
		if (last) begin
			r = '0;
			if (pp_bad || !parse_complete()) r.status = ST_SYNTAX;
			else if (pp_mode != MODE_TIME && !calendar_valid()) r.status = ST_BAD_DATE;
			else if (pp_mode != MODE_DATE && !clock_valid()) r.status = ST_BAD_TIME;
			else r.status = ST_OK;
			if (r.status != ST_SYNTAX) begin
				off = pp_zh * 60 + pp_zm;
				if (pp_zneg) off = -off;
				r.year = pp_year[YEAR_W-1:0];
				r.month = pp_month[FLD_W-1:0];
				r.day = pp_day[FLD_W-1:0];
				r.hour = pp_hour[FLD_W-1:0];
				r.minute = pp_minute[FLD_W-1:0];
				r.second = pp_second[FLD_W-1:0];
				r.microsecond = pp_frac[US_W-1:0];
				r.zone_present = pp_zpres;
				r.zone_offset = off[ZOFF_W-1:0];
			end
			due_results.push_back(r);
			status_count[r.status]++;
			parse_clear();
		end
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			{got.zone_offset, got.zone_present, got.microsecond, got.second, got.minute,
				got.hour, got.day, got.month, got.year} = m_tdata[FIELD_BITS-1:0];
			if (due_results.size() == 0) begin
				$error("result beat with no string outstanding");
				errors++;
			end else begin
				want = due_results.pop_front();
				check_field("status", want.status, m_tuser);
				check_field("year", want.year, got.year);
				check_field("month", want.month, got.month);
				check_field("day", want.day, got.day);
				check_field("hour", want.hour, got.hour);
				check_field("minute", want.minute, got.minute);
				check_field("second", want.second, got.second);
				check_field("microsecond", want.microsecond, got.microsecond);
				check_field("zone_present", want.zone_present, got.zone_present);
				check_field("zone_offset_minutes", want.zone_offset, got.zone_offset);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else if (arst_n) quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$error("no beat accepted for %0d cycles", quiet_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin : receiver
		int wait_cyc;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold) @(negedge clk);
				rx_hold = 0;
			end
			wait_cyc = rx_idle ? $urandom_range(MAX_IDLE, 0) : 0;
			if (wait_cyc > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cyc) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid && rx_hold == 0);
		end
	end

	// entered and left at a falling edge; tvalid stays high between back-to-back beats
	task automatic send_char(logic [7:0] c, logic last, logic [1:0] mode);
		int gap;
		gap = tx_idle ? $urandom_range(MAX_IDLE, 0) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= last;
		s_tuser <= mode;
		do @(posedge clk); while (!s_tready);
		track_char(c, last, mode);
		chars_sent++;
		@(negedge clk);
	endtask

	// mode is only sampled on the first beat; scramble varies it on the rest
	task automatic send_text(logic [1:0] mode, bit scramble);
		int n;
		if (text_buf.size() == 0) text_buf.push_back(ALPHABET[$urandom_range(18, 0)]);
		n = text_buf.size();
		for (int i = 0; i < n; i++)
			send_char(text_buf[i], i == n - 1,
				(i > 0 && scramble) ? 2'($urandom_range(3, 0)) : mode);
		text_buf.delete();
		strings_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (due_results.size() > 0) @(negedge clk);
	endtask

	task automatic send_str(string s, mode_t mode);
		for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
		send_text(mode, 1'b0);
	endtask

	function automatic void put_num(int unsigned v, int nd);
		int unsigned scale;
		scale = 1;
		repeat (nd - 1) scale = scale * 10;
		repeat (nd) begin
			text_buf.push_back(8'(CH_0 + (v / scale) % 10));
			scale = scale / 10;
		end
	endfunction

	function automatic void put_field(int unsigned v);
		put_num(v, (v < 10 && $urandom_range(1, 0)) ? 1 : 2);
	endfunction

	function automatic int unsigned pick_value(int unsigned hi);
		return ($urandom_range(9, 0) == 0) ? $urandom_range(99, 0) : $urandom_range(hi, 0);
	endfunction

	function automatic logic [7:0] random_char();
		return $urandom_range(1, 0) ? 8'(ALPHABET[$urandom_range(18, 0)])
			: 8'($urandom_range(255, 0));
	endfunction

	function automatic void build_date();
		int unsigned y, m, dd;
		case ($urandom_range(3, 0))
			0:       y = $urandom_range(9999, 0);
			1:       y = 4 * $urandom_range(2499, 0);
			2:       y = 100 * $urandom_range(99, 0);
			default: y = $urandom_range(2100, 1900);
		endcase
		m = ($urandom_range(7, 0) == 0) ? $urandom_range(99, 0) : $urandom_range(12, 1);
		if ($urandom_range(9, 0) == 0) dd = $urandom_range(99, 0);
		else if (m == 2 && $urandom_range(1, 0)) dd = $urandom_range(29, 28);
		else dd = $urandom_range(31, 1);
		put_num(y, 4);
		text_buf.push_back(CH_DASH);
		put_field(m);
		text_buf.push_back(CH_DASH);
		put_field(dd);
	endfunction

	function automatic void build_time();
		put_field(pick_value(23));
		text_buf.push_back(CH_COLON);
		put_field(pick_value(59));
		if ($urandom_range(2, 0) != 0) begin
			text_buf.push_back(CH_COLON);
			put_field(pick_value(59));
			if ($urandom_range(1, 0)) begin
				text_buf.push_back($urandom_range(1, 0) ? CH_DOT : CH_COMMA);
				repeat ($urandom_range(9, 1)) text_buf.push_back(8'(CH_0 + $urandom_range(9, 0)));
			end
		end
	endfunction

	function automatic void build_zone();
		int blanks;
		int kind;
		blanks = ($urandom_range(2, 0) == 0) ? $urandom_range(2, 1) : 0;
		repeat (blanks) text_buf.push_back($urandom_range(1, 0) ? CH_SPACE : CH_TAB);
		kind = $urandom_range(4, 0);
		if (kind == 1) begin
			text_buf.push_back(CH_Z);
		end else if (kind > 1) begin
			text_buf.push_back($urandom_range(1, 0) ? CH_PLUS : CH_MINUS);
			put_num($urandom_range(1, 0) ? $urandom_range(14, 0) : $urandom_range(99, 0), 2);
			if (kind == 4) text_buf.push_back(CH_COLON);
			if (kind >= 3) put_num(pick_value(59), 2);
		end
	endfunction

	function automatic void build_string(logic [1:0] mode);
		if (mode != MODE_TIME) build_date();
		if (mode == MODE_DATETIME) text_buf.push_back($urandom_range(1, 0) ? CH_T : CH_SPACE);
		if (mode != MODE_DATE) build_time();
		if (mode == MODE_DATETIME && $urandom_range(3, 0) != 0) build_zone();
	endfunction

	function automatic void corrupt_text();
		int pos;
		pos = $urandom_range(text_buf.size() - 1, 0);
		case ($urandom_range(3, 0))
			0:       text_buf[pos] = random_char();
			1:       if (text_buf.size() > 1) text_buf.delete(pos);
			2:       text_buf.insert(pos, random_char());
			default: text_buf.push_back(random_char());
		endcase
	endfunction

	task automatic test_date_strings();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_str("2024-02-29", MODE_DATE);
		send_str("1900-02-29", MODE_DATE);
		send_str("2000-2-9", MODE_DATE);
		send_str("0000-01-01", MODE_DATE);
		send_str("9999-12-31", MODE_DATE);
		send_str("2023-13-01", MODE_DATE);
		send_str("2023-04-31", MODE_DATE);
		send_str("20230-01-01", MODE_DATE);
		send_str("2023-1", MODE_DATE);
	endtask

	task automatic test_time_strings();
		send_str("23:59:59.999999", MODE_TIME);
		send_str("24:00", MODE_TIME);
		send_str("7:5", MODE_TIME);
		send_str("12:30:45,1234567", MODE_TIME);
		send_str("12:30.5", MODE_TIME);
		send_str("00:60:00", MODE_TIME);
	endtask

	task automatic test_datetime_strings();
		send_str("2024-12-31T23:59:59.5Z", MODE_DATETIME);
		send_str("1999-01-01 00:00 +05:30", MODE_DATETIME);
		send_str("2001-02-03T04:05:06-0800", MODE_DATETIME);
		send_str("2001-02-03T04:05\t-99:99", MODE_DATETIME);
		send_str("2010-06-15T12:00Z ", MODE_DATETIME);
		send_str("2010-06-15T12:00  ", MODE_DATETIME);
		send_str("2010-06-15T12:00+05", MODE_DATETIME);
		send_str("2010-06-15T12:00+5", MODE_DATETIME);
		send_str("2023-02-29T25:00", MODE_DATETIME);
		send_str("12:00", MODE_RSVD);
	endtask

	task automatic test_random_text(int n_chars, bit tx_en, bit rx_en);
		int         start;
		logic [1:0] mode;
		tx_idle = tx_en;
		rx_idle = rx_en;
		start = chars_sent;
		while (chars_sent - start < n_chars) begin
			if ($urandom_range(9, 0) == 0) begin
				// noise: arbitrary bytes in any mode
				mode = 2'($urandom_range(3, 0));
				repeat ($urandom_range(10, 1)) text_buf.push_back(8'($urandom_range(255, 0)));
			end else begin
				mode = 2'($urandom_range(2, 0));
				build_string(mode);
				if ($urandom_range(5, 0) == 0) corrupt_text();
				if ($urandom_range(11, 0) == 0) mode = 2'($urandom_range(3, 0));
			end
			send_text(mode, $urandom_range(3, 0) == 0);
		end
	endtask

	// results held back while characters keep coming, then a full pause on the input
	task automatic test_output_stall();
		drain();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold = HOLD_CYCLES;
		repeat (8) begin
			build_string(MODE_DATETIME);
			send_text(MODE_DATETIME, 1'b0);
		end
		drain();
	endtask

	initial begin
		parse_clear();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_date_strings();
		test_time_strings();
		test_datetime_strings();
		test_random_text(RANDOM_CHARS / 4, 1'b1, 1'b1);
		test_random_text(RANDOM_CHARS / 4, 1'b0, 1'b0);
		test_output_stall();
		test_random_text(RANDOM_CHARS / 4, 1'b1, 1'b0);
		test_random_text(RANDOM_CHARS / 4, 1'b0, 1'b1);
		drain();
		repeat (8) @(negedge clk);
		$display("Parsed %0d strings (%0d characters) in date, time, datetime and reserved modes",
			strings_sent, chars_sent);
		$display("Outcomes: %0d ok, %0d syntax, %0d bad date, %0d bad time",
			status_count[ST_OK], status_count[ST_SYNTAX],
			status_count[ST_BAD_DATE], status_count[ST_BAD_TIME]);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/idtp_pkg.sv
rtl/idtp_parse.sv
rtl/idtp_result.sv
rtl/iso_datetime_text_parser_top.sv
verif/tb_iso_datetime_text_parser_top.sv
